FILE: src/mau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_pkg: shared types and constants of the modular arithmetic unit
// Widths, opcodes and the divider word width used by all files of the block.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int RESIDUE_BITS  = 31;
  localparam int EXPONENT_BITS = 63;
  localparam int VALUE_BITS    = 64;
  localparam int OPCODE_BITS   = 3;
  localparam int DIV_BITS      = 64;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
  localparam int PADDR_BITS    = 3;
  localparam int PDATA_BITS    = 32;
  localparam logic [RESIDUE_BITS-1:0] MODULUS_RESET = RESIDUE_BITS'(1000000007);

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_INV = 3'd5,
    OP_RED = 3'd6,
    OP_CMP = 3'd7
  } opcode_e;

  typedef struct packed {
    logic                    done;
    logic [DIV_BITS-1:0]     quot;
    logic [RESIDUE_BITS-1:0] rem;
  } div_rsp_t;

endpackage

FILE: src/mau_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_in_if / mau_out_if: request and result channels
// Valid/ready channels carrying one request word and one result word.
// ----------------------------------------------------------------------------
interface mau_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mau_pkg::OPCODE_BITS-1:0]      opcode;
  logic [mau_pkg::RESIDUE_BITS-1:0]     operand_a;
  logic [mau_pkg::RESIDUE_BITS-1:0]     operand_b;
  logic [mau_pkg::EXPONENT_BITS-1:0]    exponent;
  logic signed [mau_pkg::VALUE_BITS-1:0] signed_value;
  modport source (output valid, opcode, operand_a, operand_b, exponent, signed_value,
                  input ready);
  modport sink (input valid, opcode, operand_a, operand_b, exponent, signed_value,
                output ready);
endinterface

interface mau_out_if;
  logic                             valid;
  logic                             ready;
  logic [mau_pkg::RESIDUE_BITS-1:0] result_value;
  logic                             is_equal;
  logic                             is_less;
  logic                             not_invertible;
  modport source (output valid, result_value, is_equal, is_less, not_invertible,
                  input ready);
  modport sink (input valid, result_value, is_equal, is_less, not_invertible,
                output ready);
endinterface

FILE: src/mau_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_div: bit-serial restoring divider
// Divides a 64-bit word by a residue-wide divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module mau_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [mau_pkg::DIV_BITS-1:0]         dividend_i,
  input  logic [mau_pkg::RESIDUE_BITS-1:0]     divisor_i,
  output mau_pkg::div_rsp_t                    rsp_o
);

  logic [mau_pkg::DIV_BITS-1:0]     dvd_q;
  logic [mau_pkg::RESIDUE_BITS-1:0] dvs_q;
  logic [mau_pkg::RESIDUE_BITS-1:0] rem_q;
  logic [mau_pkg::DIV_CNT_BITS-1:0] cnt_q;
  logic                             busy_q;
  logic                             done_q;
  logic [mau_pkg::RESIDUE_BITS:0]   shifted;
  logic                             fits;

  assign shifted = {rem_q, dvd_q[mau_pkg::DIV_BITS-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == mau_pkg::DIV_CNT_BITS'(mau_pkg::DIV_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the vacated dividend positions
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[mau_pkg::DIV_BITS-2:0], fits};
      rem_q <= fits ? mau_pkg::RESIDUE_BITS'(shifted - {1'b0, dvs_q})
                    : shifted[mau_pkg::RESIDUE_BITS-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;
  assign rsp_o.rem  = rem_q;

endmodule

FILE: src/modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit: modular add, sub, mul, div, pow, inverse, reduce
// Sequenced ALU over a programmable modulus, built on one shared divider.
// ----------------------------------------------------------------------------
// Every word goes through one shared 64-bit bit-serial divider (one bit per
// cycle) under a small sequencer; a 31x31 multiplier feeds it for modular
// products. Both operands are first reduced (two passes). Add, sub and
// compare then finish without another pass; mul and reduce-signed take one
// more pass. Pow costs one or two modular products per exponent bit up to its
// highest set bit; inverse costs two passes per iteration of t = m mod t, and
// divide adds one product. The unit takes a new word only when its sequencer
// is idle, but it does accept one while the previous result still sits in
// the output register. The modulus lives at APB address 0 (31 bits, reset
// 1000000007); values 0 and 1 act as 1. Write it only while idle.
// not_invertible marks a zero value to invert or an inverse iteration that
// hits 0, and then result_value is 0.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mau_in_if.sink                             in_i,
  mau_out_if.source                          out_o,
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [mau_pkg::PADDR_BITS-1:0]     paddr_i,
  input  logic [mau_pkg::PDATA_BITS-1:0]     pwdata_i,
  output logic [mau_pkg::PDATA_BITS-1:0]     prdata_o,
  output logic                               pready_o
);

  localparam int RB = mau_pkg::RESIDUE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RED_A, S_RED_B, S_DISPATCH, S_INV_CHK, S_INV_DIV,
    S_POW_CHK, S_MUL, S_MDIV, S_SGN, S_OUT
  } state_e;

  // what to do with a finished modular product
  typedef enum logic [1:0] {
    TAG_FINAL, TAG_INV, TAG_ACC, TAG_SQ
  } tag_e;

  state_e                            state_q;
  tag_e                              tag_q;
  mau_pkg::opcode_e                  op_q;
  logic [RB-1:0]                     mod_q;
  logic [RB-1:0]                     m_eff;
  logic [RB-1:0]                     a_q, b_q, x_q, y_q, acc_q, cur_q, res_q, t_q, r_q;
  logic [mau_pkg::EXPONENT_BITS-1:0] e_q;
  logic [mau_pkg::VALUE_BITS-1:0]    sv_q;
  logic                              eq_q, lt_q, err_q;
  logic                              start_q;
  logic [mau_pkg::DIV_BITS-1:0]      dvd_q;
  logic [RB-1:0]                     dvs_q;
  mau_pkg::div_rsp_t                 div_rsp;
  logic                              out_valid_q;
  logic [RB-1:0]                     out_res_q;
  logic                              out_eq_q, out_lt_q, out_err_q;
  logic [RB:0]                       add_sum, sub_sum;
  logic [RB-1:0]                     add_r, sub_r, one_m;
  logic [mau_pkg::VALUE_BITS-1:0]    sv_mag;
  logic                              cfg_wr;

  // configuration register
  assign cfg_wr   = psel_i && penable_i && pwrite_i && !paddr_i[2];
  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? '0 : mau_pkg::PDATA_BITS'(mod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mau_pkg::MODULUS_RESET;
    end else if (cfg_wr) begin
      mod_q <= pwdata_i[RB-1:0];
    end
  end

  assign m_eff = (mod_q < RB'(2)) ? RB'(1) : mod_q;
  assign one_m = (m_eff == RB'(1)) ? '0 : RB'(1);

  // combinational residue add and subtract
  assign add_sum = {1'b0, a_q} + {1'b0, b_q};
  assign sub_sum = {1'b0, a_q} + {1'b0, m_eff - b_q};
  assign add_r   = (add_sum >= {1'b0, m_eff}) ? RB'(add_sum - {1'b0, m_eff}) : add_sum[RB-1:0];
  assign sub_r   = (sub_sum >= {1'b0, m_eff}) ? RB'(sub_sum - {1'b0, m_eff}) : sub_sum[RB-1:0];
  assign sv_mag  = sv_q[mau_pkg::VALUE_BITS-1] ? (~sv_q + 1'b1) : sv_q;

  mau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (dvd_q),
    .divisor_i  (dvs_q),
    .rsp_o      (div_rsp)
  );

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.result_value   = out_res_q;
  assign out_o.is_equal       = out_eq_q;
  assign out_o.is_less        = out_lt_q;
  assign out_o.not_invertible = out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      tag_q       <= TAG_FINAL;
      op_q        <= mau_pkg::OP_ADD;
    end else begin
      start_q <= 1'b0;
      // drop the result word once taken, unless a new one loads now
      if (out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= mau_pkg::opcode_e'(in_i.opcode);
            e_q     <= in_i.exponent;
            sv_q    <= in_i.signed_value;
            b_q     <= in_i.operand_b;
            r_q     <= '0;
            eq_q    <= 1'b0;
            lt_q    <= 1'b0;
            err_q   <= 1'b0;
            dvd_q   <= mau_pkg::DIV_BITS'(in_i.operand_a);
            dvs_q   <= m_eff;
            start_q <= 1'b1;
            state_q <= S_RED_A;
          end
        end
        S_RED_A: begin
          if (div_rsp.done) begin
            a_q     <= div_rsp.rem;
            dvd_q   <= mau_pkg::DIV_BITS'(b_q);
            start_q <= 1'b1;
            state_q <= S_RED_B;
          end
        end
        S_RED_B: begin
          if (div_rsp.done) begin
            b_q     <= div_rsp.rem;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          res_q <= one_m;
          unique case (op_q)
            mau_pkg::OP_ADD: begin
              r_q     <= add_r;
              state_q <= S_OUT;
            end
            mau_pkg::OP_SUB: begin
              r_q     <= sub_r;
              state_q <= S_OUT;
            end
            mau_pkg::OP_MUL: begin
              x_q     <= a_q;
              y_q     <= b_q;
              tag_q   <= TAG_FINAL;
              state_q <= S_MUL;
            end
            mau_pkg::OP_DIV, mau_pkg::OP_INV: begin
              t_q <= (op_q == mau_pkg::OP_DIV) ? b_q : a_q;
              if (((op_q == mau_pkg::OP_DIV) ? b_q : a_q) == '0) begin
                err_q   <= 1'b1;
                state_q <= S_OUT;
              end else begin
                state_q <= S_INV_CHK;
              end
            end
            mau_pkg::OP_POW: begin
              acc_q   <= one_m;
              cur_q   <= a_q;
              state_q <= S_POW_CHK;
            end
            mau_pkg::OP_RED: begin
              dvd_q   <= sv_mag;
              start_q <= 1'b1;
              state_q <= S_SGN;
            end
            mau_pkg::OP_CMP: begin
              eq_q    <= (a_q == b_q);
              lt_q    <= (a_q < b_q);
              state_q <= S_OUT;
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_INV_CHK: begin
          if (t_q == RB'(1)) begin
            if (op_q == mau_pkg::OP_DIV) begin
              x_q     <= a_q;
              y_q     <= res_q;
              tag_q   <= TAG_FINAL;
              state_q <= S_MUL;
            end else begin
              r_q     <= res_q;
              state_q <= S_OUT;
            end
          end else begin
            // q = m / t and the next t = m mod t come from one pass
            dvd_q   <= mau_pkg::DIV_BITS'(m_eff);
            dvs_q   <= t_q;
            start_q <= 1'b1;
            state_q <= S_INV_DIV;
          end
        end
        S_INV_DIV: begin
          if (div_rsp.done) begin
            t_q     <= div_rsp.rem;
            x_q     <= res_q;
            y_q     <= m_eff - div_rsp.quot[RB-1:0];
            tag_q   <= TAG_INV;
            state_q <= S_MUL;
          end
        end
        S_POW_CHK: begin
          if (e_q == '0) begin
            r_q     <= acc_q;
            state_q <= S_OUT;
          end else if (e_q[0]) begin
            x_q     <= acc_q;
            y_q     <= cur_q;
            tag_q   <= TAG_ACC;
            state_q <= S_MUL;
          end else begin
            x_q     <= cur_q;
            y_q     <= cur_q;
            tag_q   <= TAG_SQ;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // register the product, then reduce it
          dvd_q   <= mau_pkg::DIV_BITS'(x_q * y_q);
          dvs_q   <= m_eff;
          start_q <= 1'b1;
          state_q <= S_MDIV;
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            unique case (tag_q)
              TAG_FINAL: begin
                r_q     <= div_rsp.rem;
                state_q <= S_OUT;
              end
              TAG_INV: begin
                res_q <= div_rsp.rem;
                if (t_q == '0) begin
                  err_q   <= 1'b1;
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_INV_CHK;
                end
              end
              TAG_ACC: begin
                acc_q   <= div_rsp.rem;
                x_q     <= cur_q;
                y_q     <= cur_q;
                tag_q   <= TAG_SQ;
                state_q <= S_MUL;
              end
              TAG_SQ: begin
                cur_q   <= div_rsp.rem;
                e_q     <= e_q >> 1;
                state_q <= S_POW_CHK;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_SGN: begin
          if (div_rsp.done) begin
            if (sv_q[mau_pkg::VALUE_BITS-1] && (div_rsp.rem != '0)) begin
              r_q <= m_eff - div_rsp.rem;
            end else begin
              r_q <= div_rsp.rem;
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_res_q   <= r_q;
            out_eq_q    <= eq_q;
            out_lt_q    <= lt_q;
            out_err_q   <= err_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_err_q |-> out_res_q == '0)
    else $error("error result with nonzero value");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_eq_q && out_lt_q))
    else $error("equal and less both set");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_res_q < m_eff)
    else $error("result not reduced");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_RED_A || state_q == S_RED_B || state_q == S_INV_DIV
                  || state_q == S_MDIV || state_q == S_SGN)
    else $error("divider finished with no one waiting");

endmodule

FILE: bench/mau_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_result_checker: result predictor and scoreboard
// Tracks the modulus from APB writes, predicts one result per request word
// and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module mau_result_checker
  import mau_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mau_in_if                     req_mon,
  mau_out_if                    rsp_mon,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [PADDR_BITS-1:0] paddr_i,
  input  logic [PDATA_BITS-1:0] pwdata_i,
  output int                    pending_o,
  output int                    errors_o
);

  localparam logic [PADDR_BITS-1:0] ADDR_MODULUS = '0;

  typedef struct packed {
    logic [RESIDUE_BITS-1:0] value;
    logic                    eq;
    logic                    lt;
    logic                    bad;
  } residue_result_t;

  logic [RESIDUE_BITS-1:0] modulus_q;
  residue_result_t         expected_results[$];
  int                      n_errors;

  // t := m - t*q with q = m / t, res *= (m - q); fails when t hits 0
  function automatic bit modular_inverse(input bit [63:0] x, input bit [63:0] m,
                                         output bit [63:0] inv);
    bit [63:0] t;
    bit [63:0] q;
    t   = x;
    inv = 64'd1 % m;
    if (t == 0) return 1'b0;
    while (t != 1) begin
      q   = m / t;
      inv = (inv * (m - q)) % m;
      t   = m - t * q;
      if (t == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic residue_result_t predict_result(
    input logic [OPCODE_BITS-1:0]   op,
    input logic [RESIDUE_BITS-1:0]  a_raw,
    input logic [RESIDUE_BITS-1:0]  b_raw,
    input logic [EXPONENT_BITS-1:0] e_raw,
    input logic [VALUE_BITS-1:0]    sv_raw,
    input logic [RESIDUE_BITS-1:0]  mod_raw);
    residue_result_t res;
    bit [63:0] m, a, b, r, iv, acc, cur, e, sv, mag;
    res = '0;
    m   = (mod_raw < 2) ? 64'd1 : 64'(mod_raw);
    a   = 64'(a_raw) % m;
    b   = 64'(b_raw) % m;
    e   = 64'(e_raw);
    sv  = sv_raw;
    r   = 0;
    case (opcode_e'(op))
      OP_ADD: begin
        r = a + b;
        if (r >= m) r -= m;
      end
      OP_SUB: begin
        r = a + (m - b);
        if (r >= m) r -= m;
      end
      OP_MUL: r = (a * b) % m;
      OP_DIV: begin
        if (modular_inverse(b, m, iv)) r = (a * iv) % m;
        else res.bad = 1'b1;
      end
      OP_POW: begin
        acc = 64'd1 % m;
        cur = a;
        while (e != 0) begin
          if (e[0]) acc = (acc * cur) % m;
          cur = (cur * cur) % m;
          e   = e >> 1;
        end
        r = acc;
      end
      OP_INV: begin
        if (modular_inverse(a, m, iv)) r = iv;
        else res.bad = 1'b1;
      end
      OP_RED: begin
        if (sv[63]) begin
          mag = ~sv + 1;
          r   = mag % m;
          r   = (r == 0) ? 0 : m - r;
        end else begin
          r = sv % m;
        end
      end
      default: begin
        res.eq = (a == b);
        res.lt = (a < b);
      end
    endcase
    res.value = r[RESIDUE_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    residue_result_t exp_r;
    residue_result_t act_r;
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
      expected_results.delete();
      n_errors  <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_MODULUS) begin
        modulus_q <= pwdata_i[RESIDUE_BITS-1:0];
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_results.push_back(predict_result(req_mon.opcode, req_mon.operand_a,
          req_mon.operand_b, req_mon.exponent, req_mon.signed_value, modulus_q));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        act_r = '{rsp_mon.result_value, rsp_mon.is_equal, rsp_mon.is_less,
                  rsp_mon.not_invertible};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $realtime, act_r);
          n_errors <= n_errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.value != act_r.value || exp_r.eq != act_r.eq ||
              exp_r.lt != act_r.lt || exp_r.bad != act_r.bad) begin
            $display("%0t: mismatch expected value=%0d eq=%b lt=%b ninv=%b",
                     $realtime, exp_r.value, exp_r.eq, exp_r.lt, exp_r.bad,
                     " actual value=%0d eq=%b lt=%b ninv=%b",
                     act_r.value, act_r.eq, act_r.lt, act_r.bad);
            n_errors <= n_errors + 1;
          end
        end
      end
    end
  end

  assign pending_o = expected_results.size();
  assign errors_o  = n_errors;

endmodule

FILE: bench/tb_modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_arithmetic_unit: regression bench of the modular arithmetic unit
// Runs directed edge words and random words for every opcode under a series
// of moduli (prime, composite, extremes, degenerate), with random gaps on
// both channels; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_modular_arithmetic_unit;
  import mau_pkg::*;

  // long inverse chains and full exponents run with no handshake in between
  localparam int WATCHDOG_LIMIT = 20000000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_PER_MOD = 133;
  localparam logic [PADDR_BITS-1:0] ADDR_MODULUS = '0;
  localparam logic [RESIDUE_BITS-1:0] RES_MAX = '1;

  logic clk;
  logic rst_n;

  mau_in_if  req_if ();
  mau_out_if rsp_if ();

  logic                  psel, penable, pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  int  pending_cnt;
  int  error_cnt;
  int  idle_cycles;
  bit  send_bursty;   // drop gaps on the sender side while set
  bit  recv_bursty;   // drop stalls on the receiver side while set

  // moduli run in order; the first phase uses the reset value unwritten
  logic [PDATA_BITS-1:0] modulus_plan[10] = '{
    32'd1000000007, 32'h8000_0002, 32'h7FFF_FFFF, 32'd1000000,
    32'h8000_0001, 32'd0, 32'd97, 32'd65536, 32'd999983, 32'd1000000007
  };

  modular_arithmetic_unit u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (req_if),
    .out_o     (rsp_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready)
  );

  mau_result_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_mon   (req_if),
    .rsp_mon   (rsp_if),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .pready_i  (pready),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .pending_o (pending_cnt),
    .errors_o  (error_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("modular_arithmetic_unit regression: fail");
      $finish;
    end
  end

  // Result side: hold ready low for a random stall before each word, then
  // wait for the handshake. In burst mode keep ready high throughout.
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    recv_bursty = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_bursty = ~recv_bursty;
      stall = recv_bursty ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  // Present one request word after a random gap; keep valid high on no gap.
  task automatic send_word(input opcode_e op, input logic [RESIDUE_BITS-1:0] a,
                           input logic [RESIDUE_BITS-1:0] b,
                           input logic [EXPONENT_BITS-1:0] e,
                           input logic [VALUE_BITS-1:0] sv);
    int gap;
    if ($urandom_range(0, 49) == 0) send_bursty = ~send_bursty;
    gap = send_bursty ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= op;
    req_if.operand_a    <= a;
    req_if.operand_b    <= b;
    req_if.exponent     <= e;
    req_if.signed_value <= sv;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // Two-phase APB write; the register takes the value at the access edge.
  task automatic write_modulus(input logic [PDATA_BITS-1:0] value);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MODULUS;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Residue operand biased toward the edges of the current modulus.
  function automatic logic [RESIDUE_BITS-1:0] pick_residue(input logic [RESIDUE_BITS-1:0] m_raw);
    logic [RESIDUE_BITS-1:0] m;
    m = (m_raw < 2) ? RESIDUE_BITS'(1) : m_raw;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return m - RESIDUE_BITS'(1);
      2:       return RES_MAX;
      3:       return m;
      4, 5:    return RESIDUE_BITS'($urandom());
      default: return RESIDUE_BITS'($urandom() % 32'(m));
    endcase
  endfunction

  // Mostly short exponents; sometimes all 63 bits random (slow on the block).
  function automatic logic [EXPONENT_BITS-1:0] pick_exponent();
    if ($urandom_range(0, 15) == 0) return EXPONENT_BITS'({$urandom(), $urandom()});
    return EXPONENT_BITS'($urandom_range(0, 63));
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_signed();
    case ($urandom_range(0, 7))
      0:       return 64'h8000_0000_0000_0000;
      1:       return 64'h7FFF_FFFF_FFFF_FFFF;
      2:       return -64'sd1;
      3:       return 64'(-$signed(64'($urandom())));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    logic [RESIDUE_BITS-1:0] mod_now;
    opcode_e op;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    req_if.valid        <= 1'b0;
    req_if.opcode       <= OP_ADD;
    req_if.operand_a    <= '0;
    req_if.operand_b    <= '0;
    req_if.exponent     <= '0;
    req_if.signed_value <= '0;
    send_bursty = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: operand extremes, zero to invert, zero power, signed extremes,
    // flags on every opcode; the reset modulus is prime.
    send_word(OP_ADD, RES_MAX, RES_MAX, '0, '0);
    send_word(OP_ADD, '0, '0, '1, '1);
    send_word(OP_SUB, '0, RES_MAX, '0, '0);
    send_word(OP_SUB, 31'd5, 31'd3, '0, '0);
    send_word(OP_MUL, RES_MAX, RES_MAX, '0, '0);
    send_word(OP_MUL, 31'd1000000006, 31'd1000000006, '0, '0);
    send_word(OP_DIV, 31'd77, '0, '0, '0);
    send_word(OP_DIV, 31'd77, 31'd1000000007, '0, '0);
    send_word(OP_DIV, 31'd77, 31'd12345, '0, '0);
    send_word(OP_POW, 31'd12345, '0, '0, '0);
    send_word(OP_POW, '0, '0, '0, '0);
    send_word(OP_POW, 31'd2, '0, '1, '0);
    send_word(OP_POW, RES_MAX, '0, 63'd1, '0);
    send_word(OP_INV, '0, '0, '0, '0);
    send_word(OP_INV, 31'd1, '0, '0, '0);
    send_word(OP_INV, RES_MAX, '0, '0, '0);
    send_word(OP_RED, '0, '0, '0, 64'h8000_0000_0000_0000);
    send_word(OP_RED, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(OP_RED, '0, '0, '0, -64'sd1);
    send_word(OP_RED, '0, '0, '0, -64'sd1000000007);
    send_word(OP_CMP, 31'd3, 31'd3, '0, '0);
    send_word(OP_CMP, 31'd2, 31'd5, '0, '0);
    send_word(OP_CMP, RES_MAX, '0, '0, '0);
    send_word(OP_CMP, 31'd1000000008, 31'd1, '0, '0);

    // Random phases, one per modulus; a composite modulus brings failing
    // inverses, zero and one make every residue zero.
    foreach (modulus_plan[p]) begin
      if (p != 0) write_modulus(modulus_plan[p]);
      mod_now = modulus_plan[p][RESIDUE_BITS-1:0];
      for (int i = 0; i < RANDOM_PER_MOD; i++) begin
        if (i == RANDOM_PER_MOD / 2) drain_results();
        op = opcode_e'($urandom_range(0, 7));
        send_word(op, pick_residue(mod_now), pick_residue(mod_now),
                  (op == OP_POW) ? pick_exponent() : 63'({$urandom(), $urandom()}),
                  pick_signed());
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("modular_arithmetic_unit regression: pass");
    end else begin
      $display("modular_arithmetic_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/mau_pkg.sv
src/mau_if.sv
src/mau_div.sv
src/modular_arithmetic_unit.sv
bench/mau_result_checker.sv
bench/tb_modular_arithmetic_unit.sv
